// ===== sv/gamepad_command_frame_sequencer_macros.svh =====
// assertion macros for the gamepad command frame sequencer
`ifndef GAMEPAD_COMMAND_FRAME_SEQUENCER_MACROS_SVH
`define GAMEPAD_COMMAND_FRAME_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define GCFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcfs assertion failed");

// next-cycle implication, disabled while in reset
`define GCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcfs assertion failed");

`endif

// ===== sv/gcfs_pkg.sv =====
// shared types, codes and tables for the gamepad command frame sequencer
package gcfs_pkg;

    // frame buffer size in bytes, header included
    localparam int FRAME_BYTES = 21;
    localparam int POS_W = 5;

    // payload capacity and header length, one bit wider than a position
    localparam logic [POS_W:0] PAYLOAD_CAP = (POS_W + 1)'(FRAME_BYTES - 3);
    localparam logic [POS_W:0] HDR_LEN = (POS_W + 1)'(3);

    // command codes
    localparam logic [2:0] CMD_POLL     = 3'd0;
    localparam logic [2:0] CMD_CHECK    = 3'd1;
    localparam logic [2:0] CMD_CONFIG   = 3'd2;
    localparam logic [2:0] CMD_MODE     = 3'd3;
    localparam logic [2:0] CMD_MOTOR    = 3'd4;
    localparam logic [2:0] CMD_PRESSURE = 3'd5;
    localparam logic [2:0] CMD_RX       = 3'd6;

    // protocol bytes
    localparam logic [7:0] BYTE_HEADER = 8'h01;
    localparam logic [7:0] BYTE_IDLE   = 8'h00;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] motor_byte_small;
        logic [7:0] motor_byte_large;
        logic       option_a;
        logic       option_b;
        logic       option_c;
        logic [7:0] rx_byte;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0]       tx_byte;
        logic             tx_valid;
        logic [POS_W-1:0] rx_index;
        logic [7:0]       rx_data;
        logic             rx_store;
        logic             frame_done;
        logic             length_error;
    } res_word_t;

    typedef struct packed {
        logic             busy;
        logic [2:0]       frame_kind;
        logic [POS_W-1:0] byte_position;
        logic [POS_W-1:0] payload_length;
        logic [15:0]      saved_motor_bytes;
        logic [2:0]       saved_options;
    } frame_state_t;

    // command byte sent in the second header slot
    function automatic logic [7:0] cmd_code(input logic [2:0] kind);
        logic [7:0] code;
        unique case (kind)
            CMD_POLL:     code = 8'h42;
            CMD_CHECK:    code = 8'h41;
            CMD_CONFIG:   code = 8'h43;
            CMD_MODE:     code = 8'h44;
            CMD_MOTOR:    code = 8'h4D;
            CMD_PRESSURE: code = 8'h4F;
            default:      code = 8'h42;
        endcase
        return code;
    endfunction

    // payload length of the fixed-length kinds
    function automatic logic [POS_W-1:0] fixed_len(input logic [2:0] kind);
        logic [POS_W-1:0] len;
        unique case (kind)
            CMD_CHECK, CMD_MODE, CMD_PRESSURE: len = POS_W'(6);
            CMD_MOTOR:                         len = POS_W'(2);
            default:                           len = '0;
        endcase
        return len;
    endfunction

    // payload byte at a payload offset
    function automatic logic [7:0] payload_byte(
        input logic [2:0]       kind,
        input logic [POS_W-1:0] idx,
        input logic [15:0]      motor,
        input logic [2:0]       opts
    );
        logic [7:0] b;
        logic       oa;
        logic       ob;
        logic       oc;
        oa = opts[0];
        ob = opts[1];
        oc = opts[2];
        b  = 8'h00;
        unique case (kind)
            CMD_POLL: begin
                if (idx == POS_W'(0)) b = motor[7:0];
                else if (idx == POS_W'(1)) b = motor[15:8];
            end
            CMD_CHECK: b = 8'h5A;
            CMD_CONFIG: begin
                if (idx == POS_W'(0)) b = {7'd0, oa};
            end
            CMD_MODE: begin
                if (idx == POS_W'(0)) b = {7'd0, oa};
                else if (idx == POS_W'(1)) b = ob ? 8'h03 : 8'hEE;
            end
            CMD_MOTOR: begin
                if (idx == POS_W'(0)) b = oa ? 8'h00 : 8'hFF;
                else if (idx == POS_W'(1)) b = ob ? 8'h01 : 8'hFF;
            end
            CMD_PRESSURE: begin
                if (idx == POS_W'(0)) b = oa ? 8'hFF : 8'h3F;
                else if (idx == POS_W'(1))
                    b = (oa ? 8'h03 : 8'h00) | (ob ? 8'h3C : 8'h00) | (oc ? 8'hC0 : 8'h00);
                else if (idx == POS_W'(2)) b = oc ? 8'h03 : 8'h00;
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/gcfs_step.sv =====
// per-word frame decision: next frame state and the result word
module gcfs_step (
    input  gcfs_pkg::frame_state_t state,
    input  gcfs_pkg::cmd_word_t    word,
    output gcfs_pkg::frame_state_t state_next,
    output gcfs_pkg::res_word_t    result
);

    logic                     variable_len;
    logic                     bad_len;
    logic [gcfs_pkg::POS_W:0] pos_inc;
    logic [gcfs_pkg::POS_W:0] frame_end;

    // kind-dependent length checks
    assign variable_len = (state.frame_kind == gcfs_pkg::CMD_POLL)
                       || (state.frame_kind == gcfs_pkg::CMD_CONFIG);
    assign bad_len = (state.payload_length == '0)
                  || ({1'b0, state.payload_length} > gcfs_pkg::PAYLOAD_CAP);
    assign pos_inc   = {1'b0, state.byte_position} + (gcfs_pkg::POS_W + 1)'(1);
    assign frame_end = gcfs_pkg::HDR_LEN + {1'b0, state.payload_length};

    // frame sequencing
    always_comb
    begin
        state_next = state;
        result     = '0;
        priority if (word.command < gcfs_pkg::CMD_RX)
        begin
            // start command, ignored while a frame is open
            if (!state.busy)
            begin
                state_next.busy              = 1'b1;
                state_next.frame_kind        = word.command;
                state_next.byte_position     = '0;
                state_next.payload_length    = gcfs_pkg::fixed_len(word.command);
                state_next.saved_motor_bytes = {word.motor_byte_large, word.motor_byte_small};
                state_next.saved_options     = {word.option_c, word.option_b, word.option_a};
                result.tx_byte               = gcfs_pkg::BYTE_HEADER;
                result.tx_valid              = 1'b1;
            end
        end
        else if (word.command == gcfs_pkg::CMD_RX && state.busy)
        begin
            result.rx_index = state.byte_position;
            result.rx_data  = word.rx_byte;
            result.rx_store = (state.frame_kind == gcfs_pkg::CMD_POLL);
            priority if (state.byte_position == gcfs_pkg::POS_W'(0))
            begin
                result.tx_byte           = gcfs_pkg::cmd_code(state.frame_kind);
                result.tx_valid          = 1'b1;
                state_next.byte_position = gcfs_pkg::POS_W'(1);
            end
            else if (state.byte_position == gcfs_pkg::POS_W'(1))
            begin
                // reported length: low nibble doubled
                if (variable_len)
                    state_next.payload_length = {word.rx_byte[3:0], 1'b0};
                result.tx_byte           = gcfs_pkg::BYTE_IDLE;
                result.tx_valid          = 1'b1;
                state_next.byte_position = gcfs_pkg::POS_W'(2);
            end
            else if (state.byte_position == gcfs_pkg::POS_W'(2) && variable_len && bad_len)
            begin
                result.frame_done   = 1'b1;
                result.length_error = 1'b1;
                state_next.busy     = 1'b0;
            end
            else if (pos_inc < frame_end)
            begin
                result.tx_byte = gcfs_pkg::payload_byte(
                    state.frame_kind,
                    gcfs_pkg::POS_W'(pos_inc - gcfs_pkg::HDR_LEN),
                    state.saved_motor_bytes,
                    state.saved_options);
                result.tx_valid          = 1'b1;
                state_next.byte_position = pos_inc[gcfs_pkg::POS_W-1:0];
            end
            else
            begin
                result.frame_done = 1'b1;
                state_next.busy   = 1'b0;
            end
        end
        else
        begin
            // stray byte or unused code: nothing happens
            state_next = state;
        end
    end

endmodule

// ===== sv/gamepad_command_frame_sequencer.sv =====
// top level of the gamepad command frame sequencer
//
//   channel   valid       stall       word
//   command   cmd_valid   cmd_stall   cmd_word (gcfs_pkg::cmd_word_t)
//   result    res_valid   res_stall   res_word (gcfs_pkg::res_word_t)
//
// one command word is taken per cycle while cmd_stall is low; its result word
// comes out of the result register in the cycle after acceptance, one result per command.
// frame state is updated at the accepting edge, so back-to-back words chain.
// cmd_stall is high only while the result register is full and res_stall holds it.
// rst_n clears the frame state and empties the result register.
`include "gamepad_command_frame_sequencer_macros.svh"

module gamepad_command_frame_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  gcfs_pkg::cmd_word_t cmd_word,
    output logic                res_valid,
    input  logic                res_stall,
    output gcfs_pkg::res_word_t res_word
);

    gcfs_pkg::frame_state_t state_reg;
    gcfs_pkg::frame_state_t state_next;
    gcfs_pkg::res_word_t    result_next;
    gcfs_pkg::res_word_t    res_word_reg;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic                   cmd_accept;

    // handshake: accept while the result register can take a word
    assign cmd_stall  = res_valid_reg && res_stall;
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign res_valid  = res_valid_reg;
    assign res_word   = res_word_reg;

    // frame decision logic
    gcfs_step u_step (
        .state      (state_reg),
        .word       (cmd_word),
        .state_next (state_next),
        .result     (result_next)
    );

    // result register occupancy
    always_comb
    begin
        if (cmd_accept)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // frame state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_accept)
                state_reg <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
            res_word_reg <= result_next;
    end

    // a byte taken while idle yields an all-zero result
    `GCFS_ASSERT_NEXT(a_idle_byte_zero, clk, rst_n,
        cmd_accept && !state_reg.busy && cmd_word.command == gcfs_pkg::CMD_RX,
        res_valid && res_word == '0)

    // a length error always closes the frame
    `GCFS_ASSERT_NEXT(a_error_closes, clk, rst_n,
        cmd_accept && result_next.length_error, !state_reg.busy)

    // an open frame never runs past the frame buffer
    `GCFS_ASSERT_NOW(a_pos_in_frame, clk, rst_n,
        state_reg.busy, 32'(state_reg.byte_position) < 32'(gcfs_pkg::FRAME_BYTES))

endmodule
